[src/mono_framebuffer_raster_engine_defines.svh]
// ----------------------------------------------------------------------------
// Raster engine assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_RASTER_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_RASTER_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// ante true implies cons true in the same cycle
`define MFRE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("raster engine check failed");
// cond never true
`define MFRE_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("raster engine check failed");
`else
`define MFRE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MFRE_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

[src/mfre_pkg.sv]
// ----------------------------------------------------------------------------
// Raster engine package
// Geometry constants, command codes and the queued command format.
// ----------------------------------------------------------------------------
package mfre_pkg;

   localparam int WIDTH       = 128;
   localparam int HEIGHT      = 128;
   localparam int BWIDTH      = (WIDTH + 7) / 8;
   localparam int STORE_BYTES = BWIDTH * HEIGHT;

   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int BCOL_W = (BWIDTH > 1) ? $clog2(BWIDTH) : 1;
   localparam int ROW_W  = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // request command codes
   localparam logic [2:0] CMD_PIXEL = 3'd0;
   localparam logic [2:0] CMD_HSPAN = 3'd1;
   localparam logic [2:0] CMD_VSPAN = 3'd2;
   localparam logic [2:0] CMD_RECT  = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;
   localparam logic [2:0] CMD_READ  = 3'd5;

   // back end operations
   localparam logic [1:0] OP_RECT  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0]  MASK_FULL     = 8'hFF;
   localparam logic [15:0] END_MASK_BASE = 16'hFF80;

   typedef struct packed {
      logic [1:0]        op;
      logic              fill;
      logic [BCOL_W-1:0] start_col;
      logic [BCOL_W-1:0] end_col;
      logic [7:0]        start_mask;
      logic [7:0]        end_mask;
      logic [ROW_W-1:0]  row_first;
      logic [ROW_W-1:0]  row_last;
      logic [ADDR_W-1:0] base;     // first row base, or read address
      logic              oob;      // read address beyond the store
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

[src/mfre_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port with per-bit write enables, one registered read port.
// ----------------------------------------------------------------------------
module mfre_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2048
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                       wr_data,
   input  logic [DATA_W-1:0]                       wr_mask,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                       rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < DATA_W; i++) begin
            if (wr_mask[i]) begin
               mem[wr_addr][i] <= wr_data[i];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mfre_front.sv]
// ----------------------------------------------------------------------------
// Raster engine front end
// Accepts request beats, range-checks them and folds every draw command
// into one rectangle form for the queue.
// ----------------------------------------------------------------------------
module mfre_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_cmd,
   input  logic [6:0]               req_x_first,
   input  logic [6:0]               req_x_last,
   input  logic [6:0]               req_y_first,
   input  logic [6:0]               req_y_last,
   input  logic                     req_color,
   input  logic [10:0]              req_byte_addr,
   input  logic                     q_full,
   input  mfre_pkg::back_status_type back_status,
   output logic                     push_valid,
   output mfre_pkg::cmd_type        push_data
);

   logic [6:0] xa, xb, ya, yb;
   logic       draw, geom_ok, known;

   always_comb begin
      xa    = req_x_first;
      xb    = req_x_first;
      ya    = req_y_first;
      yb    = req_y_first;
      draw  = 1'b0;
      known = 1'b1;
      unique case (req_cmd)
         mfre_pkg::CMD_PIXEL: draw = 1'b1;
         mfre_pkg::CMD_HSPAN: begin
            draw = 1'b1;
            xb   = req_x_last;
         end
         mfre_pkg::CMD_VSPAN: begin
            draw = 1'b1;
            yb   = req_y_last;
         end
         mfre_pkg::CMD_RECT: begin
            draw = 1'b1;
            xb   = req_x_last;
            yb   = req_y_last;
         end
         mfre_pkg::CMD_CLEAR,
         mfre_pkg::CMD_READ: ;
         default: known = 1'b0;
      endcase
   end

   assign geom_ok = (xa <= xb) && (32'(xb) < mfre_pkg::WIDTH)
                 && (ya <= yb) && (32'(yb) < mfre_pkg::HEIGHT);

   always_comb begin
      push_data            = '0;
      push_data.fill       = req_color;
      push_data.start_col  = mfre_pkg::BCOL_W'(xa >> 3);
      push_data.end_col    = mfre_pkg::BCOL_W'(xb >> 3);
      push_data.start_mask = mfre_pkg::MASK_FULL >> xa[2:0];
      push_data.end_mask   = 8'(mfre_pkg::END_MASK_BASE >> xb[2:0]);
      push_data.row_first  = mfre_pkg::ROW_W'(ya);
      push_data.row_last   = mfre_pkg::ROW_W'(yb);
      push_data.oob        = 1'b0;
      if (draw) begin
         push_data.op   = mfre_pkg::OP_RECT;
         push_data.base = mfre_pkg::ADDR_W'(32'(ya) * mfre_pkg::BWIDTH);
      end else if (req_cmd == mfre_pkg::CMD_CLEAR) begin
         push_data.op   = mfre_pkg::OP_CLEAR;
      end else begin
         push_data.op   = mfre_pkg::OP_READ;
         push_data.base = mfre_pkg::ADDR_W'(req_byte_addr);
         push_data.oob  = 32'(req_byte_addr) >= mfre_pkg::STORE_BYTES;
      end
   end

   assign req_stall  = q_full || back_status.init_busy;
   // rejected and unknown commands are accepted and dropped here
   assign push_valid = req_valid && !req_stall && known && (!draw || geom_ok);

endmodule

[src/mfre_queue.sv]
// ----------------------------------------------------------------------------
// Raster engine command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mfre_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mfre_pkg::cmd_type push_data,
   output logic              q_full,
   output logic              pop_valid,
   input  logic              pop,
   output mfre_pkg::cmd_type pop_data
);

   mfre_pkg::cmd_type             slot_ff [mfre_pkg::QDEPTH];
   logic [mfre_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mfre_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mfre_pkg::QPTR_W:0]     count_ff, count_in;
   logic                          do_push, do_pop;

   assign q_full    = count_ff == (mfre_pkg::QPTR_W+1)'(mfre_pkg::QDEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !q_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/mfre_back.sv]
// ----------------------------------------------------------------------------
// Raster engine back end
// Walks rectangles and clears one byte per cycle, serves byte reads and
// runs the white fill of the store after reset.
// ----------------------------------------------------------------------------
module mfre_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   input  mfre_pkg::cmd_type           pop_data,
   output logic                        pop,
   output mfre_pkg::back_status_type   back_status,
   output logic                        wr_en,
   output logic [mfre_pkg::ADDR_W-1:0] wr_addr,
   output logic [7:0]                  wr_data,
   output logic [7:0]                  wr_mask,
   output logic                        rd_en,
   output logic [mfre_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]                  rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_read_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RECT  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;
   localparam logic [1:0] ST_READ  = 2'd3;

   logic [1:0]                  state_ff, state_in;
   mfre_pkg::cmd_type           cur_ff, cur_in;
   logic [mfre_pkg::BCOL_W-1:0] col_ff, col_in;
   logic [mfre_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [mfre_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [mfre_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic                        init_ff, init_in;
   logic                        fill_ff, fill_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_data_ff, rsp_data_in;
   logic                        at_start, at_end, clr_last;

   assign at_start = col_ff == cur_ff.start_col;
   assign at_end   = col_ff == cur_ff.end_col;
   assign clr_last = clr_addr_ff == mfre_pkg::ADDR_W'(mfre_pkg::STORE_BYTES - 1);

   // a read is only taken when the response register is empty
   assign pop = (state_ff == ST_IDLE) && pop_valid
             && ((pop_data.op != mfre_pkg::OP_READ) || !rsp_valid_ff);

   assign rd_en   = pop && (pop_data.op == mfre_pkg::OP_READ) && !pop_data.oob;
   assign rd_addr = pop_data.base;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_mask = mfre_pkg::MASK_FULL;
      wr_data = {8{fill_ff}};
      unique case (state_ff)
         ST_RECT: begin
            wr_en   = 1'b1;
            wr_addr = base_ff + mfre_pkg::ADDR_W'(col_ff);
            wr_mask = (at_start ? cur_ff.start_mask : mfre_pkg::MASK_FULL)
                    & (at_end ? cur_ff.end_mask : mfre_pkg::MASK_FULL);
         end
         ST_CLEAR: wr_en = 1'b1;
         ST_IDLE,
         ST_READ: ;
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      clr_addr_in  = clr_addr_ff;
      init_in      = init_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cur_in  = pop_data;
               fill_in = pop_data.fill;
               unique case (pop_data.op)
                  mfre_pkg::OP_RECT: begin
                     state_in = ST_RECT;
                     col_in   = pop_data.start_col;
                     row_in   = pop_data.row_first;
                     base_in  = pop_data.base;
                  end
                  mfre_pkg::OP_CLEAR: begin
                     state_in    = ST_CLEAR;
                     clr_addr_in = '0;
                  end
                  default: begin
                     if (pop_data.oob) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_RECT: begin
            if (at_end) begin
               if (row_ff == cur_ff.row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in  = row_ff + 1'b1;
                  base_in = base_ff + mfre_pkg::ADDR_W'(mfre_pkg::BWIDTH);
                  col_in  = cur_ff.start_col;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_last) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // store comes up by a white clearing sweep
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         init_ff      <= 1'b1;
         fill_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         init_ff      <= init_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign back_status.init_busy = init_ff;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_data_ff;

endmodule

[src/mono_framebuffer_raster_engine.sv]
// ----------------------------------------------------------------------------
// Monochrome frame buffer raster engine
// 1 bpp frame store with pixel, span, rectangle, clear and byte read commands.
// ----------------------------------------------------------------------------
// Draw commands write one store byte per cycle: a span writes its byte count,
// a rectangle rows times bytes per row, a clear the whole store. An in-range
// read passes through the store's read register into the response register.
// Throughput is set by the single write port of the frame store.
// After reset the store is swept white, one byte a cycle over all STORE_BYTES
// bytes (2048 at 128x128); requests are stalled until the sweep ends.
`include "mono_framebuffer_raster_engine_defines.svh"

module mono_framebuffer_raster_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [6:0]  req_x_first,
   input  logic [6:0]  req_x_last,
   input  logic [6:0]  req_y_first,
   input  logic [6:0]  req_y_last,
   input  logic        req_color,
   input  logic [10:0] req_byte_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data
);

   mfre_pkg::back_status_type   back_status;
   mfre_pkg::cmd_type           push_data, pop_data;
   logic                        push_valid, q_full, pop_valid, pop;
   logic                        wr_en, rd_en;
   logic [mfre_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]                  wr_data, wr_mask, rd_data;

   mfre_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_x_first   (req_x_first),
      .req_x_last    (req_x_last),
      .req_y_first   (req_y_first),
      .req_y_last    (req_y_last),
      .req_color     (req_color),
      .req_byte_addr (req_byte_addr),
      .q_full        (q_full),
      .back_status   (back_status),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   mfre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   mfre_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_data      (pop_data),
      .pop           (pop),
      .back_status   (back_status),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .wr_mask       (wr_mask),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data)
   );

   mfre_ram #(
      .DATA_W (8),
      .DEPTH  (mfre_pkg::STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .wr_mask (wr_mask),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // reads are never issued while a draw or clear is writing
   `MFRE_ASSERT_NEVER(a_rd_wr_overlap, clock, reset, wr_en && rd_en)
   // a read only starts with the response register free
   `MFRE_ASSERT_IMPL(a_rd_rsp_free, clock, reset, rd_en, !rsp_valid)
   // nothing leaves the queue during the power-up sweep
   `MFRE_ASSERT_IMPL(a_no_pop_in_init, clock, reset, back_status.init_busy, !pop)

endmodule
